// ===== hdl/adcb_pkg.sv =====
// Package for the AHCI DMA command builder: sequencer states, result kinds,
// error codes, ATA opcodes and sizing constants.
// Used by ahci_dma_command_builder; no dependencies.
package adcb_pkg;

  localparam int SLOT_COUNT    = 32;
  localparam int TABLE_ENTRIES = 8;

  // The slot search looks at one byte of the busy mask per cycle.
  localparam int SCAN_WIDTH  = 8;
  localparam int SCAN_GROUPS = (SLOT_COUNT + SCAN_WIDTH - 1) / SCAN_WIDTH;
  localparam int GROUP_W     = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;
  localparam int LANE_W      = $clog2(SCAN_WIDTH);

  localparam logic [63:0] CHUNK_BYTES         = 64'd8192;
  localparam logic [12:0] FULL_CHUNK_LESS_ONE = 13'(8 * 1024 - 1);
  localparam logic [7:0]  CMD_READ_DMA_EXT    = 8'h25;
  localparam logic [7:0]  CMD_WRITE_DMA_EXT   = 8'h35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_HEAD,
    ST_DESC,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DESC   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_SLOT   = 2'd1,
    ERR_BAD_COUNT = 2'd2
  } err_t;

  // Index of the lowest set bit of one scan group.
  function automatic logic [LANE_W-1:0] lowest_set(input logic [SCAN_WIDTH-1:0] bits);
    logic [LANE_W-1:0] pos;
    pos = '0;
    for (int i = SCAN_WIDTH - 1; i >= 0; i--) begin
      if (bits[i]) pos = LANE_W'(i);
    end
    return pos;
  endfunction

endpackage

// ===== hdl/ahci_dma_command_builder.sv =====
// AHCI DMA command builder: slot search, request checks, header and
// descriptor generation around one shared 64-bit address adder.
// Depends on adcb_pkg.
//
//  Channel | Direction | Handshake          | Carries
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | one read or write request
//  out_    | output    | out_valid/out_stall| header, descriptors, or an error
//
// A request is captured, searched for a free slot (one byte of the busy
// mask per cycle) and count-checked; then one result per cycle follows
// while the output is not stalled: a header and up to eight descriptors
// for a full table. The output register lets the last result wait while
// the next request is taken. Reset is synchronous and clears the sequencer and
// out_valid only. Stalls on the output hold the sequencer in its current result.
module ahci_dma_command_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [47:0] in_start_lba,
  input  logic [15:0] in_sector_count,
  input  logic [63:0] in_buffer_address,
  input  logic [31:0] in_busy_slots,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [4:0]  out_slot,
  output logic        out_write_flag,
  output logic [7:0]  out_ata_command,
  output logic [3:0]  out_entry_total,
  output logic [47:0] out_lba_out,
  output logic [15:0] out_count_out,
  output logic [63:0] out_chunk_address,
  output logic [12:0] out_chunk_bytes_less_one,
  output logic [1:0]  out_error_code
);
  import adcb_pkg::*;

  state_t state_r, state_nxt;

  logic        wr_r, wr_nxt;
  logic [47:0] lba_r, lba_nxt;
  logic [15:0] count_r, count_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [31:0] busy_r, busy_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic [4:0]  slot_r, slot_nxt;
  logic [3:0]  entries_r, entries_nxt;
  logic [3:0]  idx_r, idx_nxt;
  err_t        err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic        last_r, last_nxt;
  logic [4:0]  oslot_r, oslot_nxt;
  logic        owr_r, owr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [3:0]  total_r, total_nxt;
  logic [47:0] olba_r, olba_nxt;
  logic [15:0] ocount_r, ocount_nxt;
  logic [63:0] caddr_r, caddr_nxt;
  logic [12:0] cbytes_r, cbytes_nxt;
  err_t        oerr_r, oerr_nxt;

  logic        in_take;
  logic        out_free;
  logic [SCAN_WIDTH-1:0] free_bits;
  logic        group_hit;
  logic        last_group;
  logic [15:0] count_less_one;
  logic [12:0] entries_full;
  logic        count_bad;
  logic        desc_last;
  logic [63:0] addr_sum;
  logic [31:0] slot_pad;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Slots at or beyond the slot count are treated as busy.
  always_comb begin
    slot_pad = '0;
    for (int i = SLOT_COUNT; i < 32; i++) slot_pad[i] = 1'b1;
  end

  assign free_bits  = ~busy_r[SCAN_WIDTH-1:0];
  assign group_hit  = |free_bits;
  assign last_group = (group_r == GROUP_W'(SCAN_GROUPS - 1));

  assign count_less_one = count_r - 16'd1;
  assign entries_full   = 13'({1'b0, count_less_one[15:4]} + 13'd1);
  assign count_bad      = (count_r == 16'd0) || (entries_full > 13'(TABLE_ENTRIES));

  assign desc_last = (idx_r == entries_r - 4'd1);
  // Shared address adder: advances the chunk address by one 8 KiB chunk.
  assign addr_sum  = addr_r + CHUNK_BYTES;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_take) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (group_hit)       state_nxt = ST_CHECK;
        else if (last_group) state_nxt = ST_ERR;
      end
      ST_CHECK: state_nxt = count_bad ? ST_ERR : ST_HEAD;
      ST_HEAD:  if (out_free) state_nxt = ST_DESC;
      ST_DESC:  if (out_free && desc_last) state_nxt = ST_IDLE;
      ST_ERR:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result register.
  always_comb begin
    wr_nxt        = wr_r;
    lba_nxt       = lba_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    busy_nxt      = busy_r;
    group_nxt     = group_r;
    slot_nxt      = slot_r;
    entries_nxt   = entries_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    oslot_nxt     = oslot_r;
    owr_nxt       = owr_r;
    cmd_nxt       = cmd_r;
    total_nxt     = total_r;
    olba_nxt      = olba_r;
    ocount_nxt    = ocount_r;
    caddr_nxt     = caddr_r;
    cbytes_nxt    = cbytes_r;
    oerr_nxt      = oerr_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          wr_nxt    = in_req_type;
          lba_nxt   = in_start_lba;
          count_nxt = in_sector_count;
          addr_nxt  = in_buffer_address;
          busy_nxt  = in_busy_slots | slot_pad;
          group_nxt = '0;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (group_hit) begin
          slot_nxt = 5'({group_r, lowest_set(free_bits)});
        end else begin
          busy_nxt  = busy_r >> SCAN_WIDTH;
          group_nxt = group_r + GROUP_W'(1);
          err_nxt   = ERR_NO_SLOT;
        end
      end
      ST_CHECK: begin
        entries_nxt = entries_full[3:0];
        err_nxt     = ERR_BAD_COUNT;
      end
      ST_HEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_HEADER;
          last_nxt      = 1'b0;
          oslot_nxt     = slot_r;
          owr_nxt       = wr_r;
          cmd_nxt       = wr_r ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT;
          total_nxt     = entries_r;
          olba_nxt      = lba_r;
          ocount_nxt    = count_r;
          caddr_nxt     = '0;
          cbytes_nxt    = '0;
          oerr_nxt      = ERR_NONE;
        end
      end
      ST_DESC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DESC;
          last_nxt      = desc_last;
          oslot_nxt     = slot_r;
          owr_nxt       = wr_r;
          cmd_nxt       = '0;
          total_nxt     = entries_r;
          olba_nxt      = '0;
          ocount_nxt    = '0;
          caddr_nxt     = addr_r;
          // The final chunk holds the count modulo 16 sectors, where zero means 16.
          cbytes_nxt    = desc_last ? ({count_r[3:0], 9'd0} - 13'd1) : FULL_CHUNK_LESS_ONE;
          oerr_nxt      = ERR_NONE;
          addr_nxt      = addr_sum;
          idx_nxt       = idx_r + 4'd1;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ERROR;
          last_nxt      = 1'b1;
          oslot_nxt     = '0;
          owr_nxt       = 1'b0;
          cmd_nxt       = '0;
          total_nxt     = '0;
          olba_nxt      = '0;
          ocount_nxt    = '0;
          caddr_nxt     = '0;
          cbytes_nxt    = '0;
          oerr_nxt      = err_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r      <= wr_nxt;
    lba_r     <= lba_nxt;
    count_r   <= count_nxt;
    addr_r    <= addr_nxt;
    busy_r    <= busy_nxt;
    group_r   <= group_nxt;
    slot_r    <= slot_nxt;
    entries_r <= entries_nxt;
    idx_r     <= idx_nxt;
    err_r     <= err_nxt;
    kind_r    <= kind_nxt;
    last_r    <= last_nxt;
    oslot_r   <= oslot_nxt;
    owr_r     <= owr_nxt;
    cmd_r     <= cmd_nxt;
    total_r   <= total_nxt;
    olba_r    <= olba_nxt;
    ocount_r  <= ocount_nxt;
    caddr_r   <= caddr_nxt;
    cbytes_r  <= cbytes_nxt;
    oerr_r    <= oerr_nxt;
  end

  assign out_valid                = out_valid_r;
  assign out_kind                 = kind_r;
  assign out_last                 = last_r;
  assign out_slot                 = oslot_r;
  assign out_write_flag           = owr_r;
  assign out_ata_command          = cmd_r;
  assign out_entry_total          = total_r;
  assign out_lba_out              = olba_r;
  assign out_count_out            = ocount_r;
  assign out_chunk_address        = caddr_r;
  assign out_chunk_bytes_less_one = cbytes_r;
  assign out_error_code           = oerr_r;

  // An accepted transaction always starts the slot search.
  a_take_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_SCAN)
    else $error("accepted request did not start the slot search");

  // Descriptor emission never runs past the entry count of the header.
  a_desc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DESC |-> (idx_r < entries_r))
    else $error("descriptor index beyond entry count");

  // A header always announces between one and the table size of entries.
  a_head_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_HEADER) |->
      (total_r != 4'd0 && total_r <= 4'(TABLE_ENTRIES) && !last_r))
    else $error("header with an impossible entry count");

  // Error results close the request and carry a real error code.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_ERROR) |->
      (last_r && (oerr_r == ERR_NO_SLOT || oerr_r == ERR_BAD_COUNT)))
    else $error("malformed error result");

  // A result loaded while the sequencer is not yet emitting would be spurious.
  a_no_load_early: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_CHECK) |=> !$rose(out_valid_r))
    else $error("result appeared during search or check");

endmodule
